// File: rtl/core/ocp_pkg.sv
// Orbit camera placement: shared constants, types and the CORDIC arctan table.
// No dependencies; every file of the block but ocp_if imports this package.
package ocp_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CNT_W = ($clog2(CORDIC_STEPS) > 4) ? $clog2(CORDIC_STEPS) : 4;

	localparam longint PITCH_LIMIT = 5832704;
	localparam longint DEG90 = 5898240;
	localparam longint DEG180 = 11796480;
	localparam longint DEG360 = 23592960;
	localparam longint RAD_PER_DEG_Q32 = 74961321;
	localparam longint CORDIC_GAIN = 652032874;
	localparam int WRAP_TOP = 8;
	localparam longint WRAP_BIAS = DEG360 * 256;

	typedef enum logic [2:0] {
		REG_PITCH_ANGLE    = 3'd0,
		REG_TURN_RATE      = 3'd1,
		REG_ZOOM_RATE      = 3'd2,
		REG_RADIUS_FLOOR   = 3'd3,
		REG_RADIUS_CEILING = 3'd4,
		REG_INPUT_ENABLE   = 3'd5,
		REG_START_YAW      = 3'd6,
		REG_START_RADIUS   = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MUL_LD, ST_MUL_LR, ST_MUL_ZD, ST_MUL_ZR, ST_RAD, ST_WRAP,
		ST_CLAMP, ST_PINIT, ST_PROT, ST_YINIT, ST_YROT, ST_FIN_RC, ST_FIN_Y,
		ST_FIN_X, ST_FIN_Z, ST_COMMIT, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		MUL_NONE, MUL_LOOK_DT, MUL_STEP_TURN, MUL_ZOOM_DT, MUL_STEP_ZOOM,
		MUL_PITCH_RAD, MUL_YAW_RAD, MUL_R_CP, MUL_R_SP, MUL_RC_SY, MUL_RC_CY
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_YAW_STEP, OP_RAD_STEP, OP_WRAP, OP_CLAMP, OP_PINIT,
		OP_YINIT, OP_ROTATE, OP_TAKE_RC, OP_TAKE_Y, OP_TAKE_X, OP_TAKE_Z
	} op_t;

	typedef struct packed {
		logic             in_ready;
		logic             out_load;
		op_t              op;
		mul_sel_t         mul;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic active;
		logic integ;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic signed [23:0] pitch_angle;
		logic signed [31:0] turn_rate;
		logic signed [31:0] zoom_rate;
		logic [30:0]        radius_floor;
		logic [30:0]        radius_ceiling;
		logic               input_enable;
		logic signed [24:0] yaw_now;
		logic [30:0]        radius_now;
		logic [31:0]        placed;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic signed [24:0] yaw;
		logic [30:0]        radius;
		logic signed [23:0] pitch;
	} commit_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h3243F6A8;
			5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFC;
			5'd3: v = 32'h07F56EA6;
			5'd4: v = 32'h03FEAB76;
			5'd5: v = 32'h01FFD55B;
			5'd6: v = 32'h00FFFAAA;
			5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEA;
			5'd9: v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/ocp_if.sv
// Orbit camera placement: valid/ready channel interfaces for frames and placements.
// Depends on nothing.
interface ocp_frame_if;
	logic               valid;
	logic               ready;
	logic               is_playing;
	logic               camera_found;
	logic [31:0]        target_id;
	logic signed [31:0] pivot_x;
	logic signed [31:0] pivot_y;
	logic signed [31:0] pivot_z;
	logic               input_present;
	logic signed [15:0] look_axis;
	logic signed [15:0] zoom_axis;
	logic [15:0]        frame_time;

	modport source (output valid, is_playing, camera_found, target_id, pivot_x, pivot_y,
		pivot_z, input_present, look_axis, zoom_axis, frame_time, input ready);
	modport sink (input valid, is_playing, camera_found, target_id, pivot_x, pivot_y,
		pivot_z, input_present, look_axis, zoom_axis, frame_time, output ready);
endinterface

interface ocp_place_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] cam_x;
	logic signed [31:0] cam_y;
	logic signed [31:0] cam_z;
	logic signed [23:0] aim_pitch;
	logic [24:0]        aim_yaw;
	logic [31:0]        placed_total;
	logic [31:0]        last_target;

	modport source (output valid, cam_x, cam_y, cam_z, aim_pitch, aim_yaw, placed_total,
		last_target, input ready);
	modport sink (input valid, cam_x, cam_y, cam_z, aim_pitch, aim_yaw, placed_total,
		last_target, output ready);
endinterface

// File: rtl/core/ocp_regs.sv
// Orbit camera placement: APB register file plus the persistent orbit state.
// Depends on ocp_pkg; takes commits from ocp_dp.
module ocp_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  ocp_pkg::commit_t commit,
	output ocp_pkg::cfg_t    cfg
);
	import ocp_pkg::*;

	logic signed [23:0] pitch_q;
	logic signed [31:0] turn_q;
	logic signed [31:0] zoom_q;
	logic [30:0]        floor_q;
	logic [30:0]        ceil_q;
	logic               enable_q;
	logic signed [24:0] start_yaw_q;
	logic [30:0]        start_rad_q;
	logic signed [24:0] yaw_q;
	logic [30:0]        radius_q;
	logic [31:0]        placed_q;
	logic               wr;
	reg_idx_t           idx;
	logic signed [26:0] yaw_t;
	logic signed [26:0] yaw_w;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[4:2]);

	// bring a start yaw into [-180,180)
	always_comb begin
		yaw_t = 27'(signed'(pwdata[24:0])) + 27'(DEG180);
		if (yaw_t < 0) begin
			yaw_w = yaw_t + 27'(DEG360) - 27'(DEG180);
		end else if (yaw_t >= 27'(DEG360)) begin
			yaw_w = yaw_t - 27'(DEG360) - 27'(DEG180);
		end else begin
			yaw_w = yaw_t - 27'(DEG180);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= 24'sd1310720;
			turn_q <= 32'sd5898240;
			zoom_q <= 32'sd655360;
			floor_q <= 31'd65536;
			ceil_q <= 31'd6553600;
			enable_q <= 1'b1;
			start_yaw_q <= '0;
			start_rad_q <= 31'd655360;
			yaw_q <= '0;
			radius_q <= 31'd655360;
			placed_q <= '0;
		end else if (commit.valid) begin
			pitch_q <= commit.pitch;
			yaw_q <= commit.yaw;
			radius_q <= commit.radius;
			placed_q <= placed_q + 32'd1;
		end else if (wr) begin
			case (idx)
				REG_PITCH_ANGLE: pitch_q <= pwdata[23:0];
				REG_TURN_RATE: turn_q <= pwdata;
				REG_ZOOM_RATE: zoom_q <= pwdata;
				REG_RADIUS_FLOOR: floor_q <= pwdata[30:0];
				REG_RADIUS_CEILING: ceil_q <= pwdata[30:0];
				REG_INPUT_ENABLE: enable_q <= pwdata[0];
				REG_START_YAW: begin
					start_yaw_q <= pwdata[24:0];
					yaw_q <= yaw_w[24:0];
				end
				REG_START_RADIUS: begin
					start_rad_q <= pwdata[30:0];
					radius_q <= pwdata[30:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PITCH_ANGLE: prdata = 32'(pitch_q);
			REG_TURN_RATE: prdata = turn_q;
			REG_ZOOM_RATE: prdata = zoom_q;
			REG_RADIUS_FLOOR: prdata = {1'b0, floor_q};
			REG_RADIUS_CEILING: prdata = {1'b0, ceil_q};
			REG_INPUT_ENABLE: prdata = {31'd0, enable_q};
			REG_START_YAW: prdata = 32'(start_yaw_q);
			REG_START_RADIUS: prdata = {1'b0, start_rad_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.pitch_angle = pitch_q;
	assign cfg.turn_rate = turn_q;
	assign cfg.zoom_rate = zoom_q;
	assign cfg.radius_floor = floor_q;
	assign cfg.radius_ceiling = ceil_q;
	assign cfg.input_enable = enable_q;
	assign cfg.yaw_now = yaw_q;
	assign cfg.radius_now = radius_q;
	assign cfg.placed = placed_q;

endmodule

// File: rtl/core/ocp_ctrl.sv
// Orbit camera placement: sequencing state machine.
// Depends on ocp_pkg; drives ocp_dp through cmd_t and reads status_t.
module ocp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  ocp_pkg::status_t status,
	output ocp_pkg::cmd_t    cmd
);
	import ocp_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_last;

	assign cnt_last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (status.in_valid && status.active) begin
					state_d = status.integ ? ST_MUL_LD : ST_CLAMP;
				end
			end
			ST_MUL_LD: state_d = ST_MUL_LR;
			ST_MUL_LR: state_d = ST_MUL_ZD;
			ST_MUL_ZD: state_d = ST_MUL_ZR;
			ST_MUL_ZR: state_d = ST_RAD;
			ST_RAD: state_d = ST_WRAP;
			ST_WRAP: if (cnt_q == '0) state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_PINIT;
			ST_PINIT: state_d = ST_PROT;
			ST_PROT: if (cnt_last) state_d = ST_YINIT;
			ST_YINIT: state_d = ST_YROT;
			ST_YROT: if (cnt_last) state_d = ST_FIN_RC;
			ST_FIN_RC: state_d = ST_FIN_Y;
			ST_FIN_Y: state_d = ST_FIN_X;
			ST_FIN_X: state_d = ST_FIN_Z;
			ST_FIN_Z: state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_OUT;
			ST_OUT: if (status.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		cmd.mul = MUL_NONE;
		cmd.cnt = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (status.in_valid) cmd.op = OP_LOAD;
			end
			ST_MUL_LD: cmd.mul = MUL_LOOK_DT;
			ST_MUL_LR: cmd.mul = MUL_STEP_TURN;
			ST_MUL_ZD: begin
				cmd.op = OP_YAW_STEP;
				cmd.mul = MUL_ZOOM_DT;
			end
			ST_MUL_ZR: cmd.mul = MUL_STEP_ZOOM;
			ST_RAD: cmd.op = OP_RAD_STEP;
			ST_WRAP: cmd.op = OP_WRAP;
			ST_CLAMP: begin
				cmd.op = OP_CLAMP;
				cmd.mul = MUL_PITCH_RAD;
			end
			ST_PINIT: begin
				cmd.op = OP_PINIT;
				cmd.mul = MUL_YAW_RAD;
			end
			ST_PROT: cmd.op = OP_ROTATE;
			ST_YINIT: cmd.op = OP_YINIT;
			ST_YROT: cmd.op = OP_ROTATE;
			ST_FIN_RC: cmd.mul = MUL_R_CP;
			ST_FIN_Y: begin
				cmd.op = OP_TAKE_RC;
				cmd.mul = MUL_R_SP;
			end
			ST_FIN_X: begin
				cmd.op = OP_TAKE_Y;
				cmd.mul = MUL_RC_SY;
			end
			ST_FIN_Z: begin
				cmd.op = OP_TAKE_X;
				cmd.mul = MUL_RC_CY;
			end
			ST_COMMIT: cmd.op = OP_TAKE_Z;
			ST_OUT: cmd.out_load = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_RAD: cnt_q <= CNT_W'(WRAP_TOP);
				ST_WRAP: cnt_q <= cnt_q - 1'b1;
				ST_PINIT: cnt_q <= '0;
				ST_YINIT: cnt_q <= '0;
				ST_PROT: cnt_q <= cnt_q + 1'b1;
				ST_YROT: cnt_q <= cnt_q + 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/ocp_dp.sv
// Orbit camera placement: datapath with the shared multiplier, yaw wrap,
// clamps, CORDIC rotator and output register. Depends on ocp_pkg and ocp_if.
module ocp_dp (
	input  logic             clk,
	input  logic             arst_n,
	ocp_frame_if.sink        frm,
	ocp_place_if.source      plc,
	input  ocp_pkg::cfg_t    cfg,
	input  ocp_pkg::cmd_t    cmd,
	output ocp_pkg::status_t status,
	output ocp_pkg::commit_t commit
);
	import ocp_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic signed [15:0] look_q, zoom_q;
	logic [15:0]        dt_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [31:0]        target_q;
	logic signed [65:0] prod_q;
	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [65:0] prod_r30, prod_r18;
	logic [34:0]        wrap_q;
	logic [34:0]        wrap_cmp;
	logic signed [35:0] rad_q;
	logic signed [35:0] rad_hi;
	logic [30:0]        r_q;
	logic signed [24:0] yaw_q;
	logic signed [25:0] yaw_fix;
	logic signed [24:0] yaw_adj;
	logic               yaw_flip;
	logic signed [23:0] pitch_c;
	logic signed [23:0] pitch_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] dx, dy;
	logic signed [33:0] atan_v;
	logic               neg_q;
	logic signed [33:0] cp_q, sp_q;
	logic signed [33:0] sy, cy;
	logic signed [33:0] rc_q;
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [31:0]        total_q;
	logic               out_vld_q;
	logic signed [39:0] pos_off;

	assign status.in_valid = frm.valid;
	assign status.active = frm.is_playing && frm.camera_found;
	assign status.integ = cfg.input_enable && frm.input_present && (frm.frame_time != '0);
	assign status.out_free = !out_vld_q || plc.ready;
	assign frm.ready = cmd.in_ready;

	assign prod_r30 = (prod_q + 66'sd536870912) >>> 30;
	assign prod_r18 = (prod_q + 66'sd131072) >>> 18;
	assign pos_off = prod_r30[39:0];

	// pitch limited to +-89 degrees
	always_comb begin
		if (cfg.pitch_angle > 24'(PITCH_LIMIT)) begin
			pitch_c = 24'(PITCH_LIMIT);
		end else if (cfg.pitch_angle < -24'(PITCH_LIMIT)) begin
			pitch_c = -24'(PITCH_LIMIT);
		end else begin
			pitch_c = cfg.pitch_angle;
		end
	end

	// fold yaw into [-90,90]; the flip negates sine and cosine afterwards
	always_comb begin
		yaw_flip = 1'b1;
		if (yaw_q > 25'(DEG90)) begin
			yaw_fix = 26'(yaw_q) - 26'(DEG180);
		end else if (yaw_q < -25'(DEG90)) begin
			yaw_fix = 26'(yaw_q) + 26'(DEG180);
		end else begin
			yaw_fix = 26'(yaw_q);
			yaw_flip = 1'b0;
		end
		yaw_adj = yaw_fix[24:0];
	end

	assign sy = neg_q ? -y_q : y_q;
	assign cy = neg_q ? -x_q : x_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul)
			MUL_LOOK_DT: begin
				mul_a = 34'(look_q);
				mul_b = signed'({16'd0, dt_q});
			end
			MUL_STEP_TURN: begin
				mul_a = prod_q[33:0];
				mul_b = cfg.turn_rate;
			end
			MUL_ZOOM_DT: begin
				mul_a = 34'(zoom_q);
				mul_b = signed'({16'd0, dt_q});
			end
			MUL_STEP_ZOOM: begin
				mul_a = prod_q[33:0];
				mul_b = cfg.zoom_rate;
			end
			MUL_PITCH_RAD: begin
				mul_a = 34'(pitch_c);
				mul_b = 32'(RAD_PER_DEG_Q32);
			end
			MUL_YAW_RAD: begin
				mul_a = 34'(yaw_adj);
				mul_b = 32'(RAD_PER_DEG_Q32);
			end
			MUL_R_CP: begin
				mul_a = signed'({3'd0, r_q});
				mul_b = cp_q[31:0];
			end
			MUL_R_SP: begin
				mul_a = signed'({3'd0, r_q});
				mul_b = sp_q[31:0];
			end
			MUL_RC_SY: begin
				mul_a = rc_q;
				mul_b = sy[31:0];
			end
			MUL_RC_CY: begin
				mul_a = rc_q;
				mul_b = cy[31:0];
			end
			default: ;
		endcase
	end

	assign wrap_cmp = 35'(DEG360) << cmd.cnt;
	assign rad_hi = (rad_q > signed'({5'd0, cfg.radius_ceiling})) ?
		signed'({5'd0, cfg.radius_ceiling}) : rad_q;
	assign dx = y_q >>> cmd.cnt;
	assign dy = x_q >>> cmd.cnt;
	assign atan_v = signed'({2'd0, atan_lut(5'(cmd.cnt))});

	always_ff @(posedge clk) begin
		if (cmd.mul != MUL_NONE) prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: begin
				look_q <= frm.look_axis;
				zoom_q <= frm.zoom_axis;
				dt_q <= frm.frame_time;
				px_q <= frm.pivot_x;
				py_q <= frm.pivot_y;
				pz_q <= frm.pivot_z;
				target_q <= frm.target_id;
				yaw_q <= cfg.yaw_now;
				wrap_q <= 35'(36'(cfg.yaw_now) + 36'(DEG180));
				rad_q <= signed'({5'd0, cfg.radius_now});
			end
			OP_YAW_STEP: begin
				wrap_q <= 35'(40'(yaw_q) + prod_r30[39:0] + 40'(DEG180) + 40'(WRAP_BIAS));
			end
			OP_RAD_STEP: rad_q <= rad_q - prod_r30[35:0];
			OP_WRAP: if (wrap_q >= wrap_cmp) wrap_q <= wrap_q - wrap_cmp;
			OP_CLAMP: begin
				yaw_q <= 25'(signed'({1'b0, wrap_q[24:0]}) - 26'(DEG180));
				pitch_q <= pitch_c;
				if (rad_hi < signed'({5'd0, cfg.radius_floor})) begin
					r_q <= cfg.radius_floor;
				end else begin
					r_q <= rad_hi[30:0];
				end
			end
			OP_PINIT: begin
				z_q <= prod_r18[33:0];
				x_q <= 34'(CORDIC_GAIN);
				y_q <= '0;
				neg_q <= yaw_flip;
			end
			OP_YINIT: begin
				cp_q <= x_q;
				sp_q <= y_q;
				z_q <= prod_r18[33:0];
				x_q <= 34'(CORDIC_GAIN);
				y_q <= '0;
			end
			OP_ROTATE: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_v;
				end
			end
			OP_TAKE_RC: rc_q <= prod_r30[33:0];
			OP_TAKE_Y: cam_y_q <= sat32(40'(py_q) + pos_off);
			OP_TAKE_X: cam_x_q <= sat32(40'(px_q) + pos_off);
			OP_TAKE_Z: begin
				cam_z_q <= sat32(40'(pz_q) + pos_off);
				total_q <= cfg.placed + 32'd1;
			end
			default: ;
		endcase
	end

	assign commit.valid = (cmd.op == OP_TAKE_Z);
	assign commit.yaw = yaw_q;
	assign commit.radius = r_q;
	assign commit.pitch = pitch_q;

	// output register: hold until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (plc.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			plc.cam_x <= cam_x_q;
			plc.cam_y <= cam_y_q;
			plc.cam_z <= cam_z_q;
			plc.aim_pitch <= pitch_q;
			plc.aim_yaw <= 25'(26'(yaw_q) + 26'(DEG180));
			plc.placed_total <= total_q;
			plc.last_target <= target_q;
		end
	end

	assign plc.valid = out_vld_q;

endmodule

// File: rtl/core/orbit_camera_placement_top.sv
// Orbit camera placement: top level joining registers, controller and datapath.
// Depends on ocp_pkg, ocp_if, ocp_regs, ocp_ctrl and ocp_dp.
//
//  channel | dir | handshake             | transaction
//  --------+-----+-----------------------+-----------------------------------
//  frm     | in  | valid / ready         | one frame: play flags, pivot, axes
//  plc     | out | valid / ready         | one placement: position, aim, count
//  apb     | in  | psel/penable/pready   | one register write or read
//
// Sequence: a frame that is dropped (not playing or no camera) is taken in the idle
// state and yields no placement. An acted frame passes the multiply, step and wrap
// states only when the axes integrate; two sequential CORDIC passes on one rotator
// and the single shared multiplier make up the rest of its sequence.
// Reset: arst_n clears the registers to their defaults and the orbit state.
// Stalls: a finished placement waits in the output register; the next frame
// is taken meanwhile, and only its own result waits for that register.
module orbit_camera_placement_top (
	input  logic        clk,
	input  logic        arst_n,
	ocp_frame_if.sink   frm,
	ocp_place_if.source plc,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ocp_pkg::*;

	cfg_t    cfg;
	commit_t commit;
	cmd_t    cmd;
	status_t status;

	// configuration and persistent yaw, radius, pitch and count
	ocp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.commit  (commit),
		.cfg     (cfg)
	);

	// sequence: integrate, wrap, clamp, two CORDIC passes, projection
	ocp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// arithmetic and the output register
	ocp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.frm    (frm),
		.plc    (plc),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status),
		.commit (commit)
	);

endmodule

// File: rtl/core/ocp_checker.sv
// Orbit camera placement: port-level checks, bound to the top level.
// Depends on ocp_pkg and orbit_camera_placement_top.
module ocp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               frm_valid,
	input logic               frm_ready,
	input logic               frm_is_playing,
	input logic               frm_camera_found,
	input logic               plc_valid,
	input logic               plc_ready,
	input logic signed [23:0] plc_aim_pitch,
	input logic [31:0]        plc_placed_total
);
	import ocp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		plc_valid && !plc_ready |=> plc_valid)
		else $error("placement dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		plc_valid && !plc_ready |=> $stable(plc_placed_total))
		else $error("placement count changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm_ready && frm_is_playing && frm_camera_found |=> !frm_ready)
		else $error("frame taken while a placement is in progress");

	a_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		plc_valid |-> (plc_aim_pitch <= 24'(PITCH_LIMIT)) &&
			(plc_aim_pitch >= -24'(PITCH_LIMIT)))
		else $error("aim pitch outside the limit");

endmodule

bind orbit_camera_placement_top ocp_checker u_ocp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.frm_valid        (frm.valid),
	.frm_ready        (frm.ready),
	.frm_is_playing   (frm.is_playing),
	.frm_camera_found (frm.camera_found),
	.plc_valid        (plc.valid),
	.plc_ready        (plc.ready),
	.plc_aim_pitch    (plc.aim_pitch),
	.plc_placed_total (plc.placed_total)
);

// File: tb/tb_orbit_camera_placement_top.sv
// Testbench for orbit_camera_placement_top: random and directed frames checked
// against an in-bench fixed-point camera predictor. Needs ocp_pkg, ocp_if and the RTL.
`timescale 1ns / 1ps

module tb_orbit_camera_placement_top;
	import ocp_pkg::*;

	localparam int  N_PHASES   = 8;
	localparam int  PHASE_LEN  = 200;
	localparam int  SETTLE     = 120;       // settle margin, above the longest acted frame
	localparam int  HOLD_LEN   = 3000;      // long receiver hold-off
	localparam longint CYCLE_LIMIT = 2000000;
	localparam longint LIM_PITCH = 5832704;
	localparam longint Q_DEG90   = 5898240;
	localparam longint Q_DEG180  = 11796480;
	localparam longint Q_DEG360  = 23592960;
	localparam longint RAD_PER_DEG = 74961321;
	localparam longint GAIN_Q30  = 652032874;

	typedef struct {
		bit          playing;
		bit          cam;
		bit [31:0]   target;
		bit [31:0]   px, py, pz;
		bit          present;
		bit [15:0]   look, zoom;
		bit [15:0]   dt;
	} frame_t;

	typedef struct packed {
		bit [31:0] x, y, z;
		bit [23:0] pitch;
		bit [24:0] yaw;
		bit [31:0] total;
		bit [31:0] target;
	} placement_t;

	// Camera state mirror, expected placement queue and result checker.
	class placement_board;
		longint pitch, turn, zoom, rfloor, rceil, yaw, rad;
		bit     enable;
		bit [31:0] count;
		placement_t due[$];
		int errors;
		longint atan_q30[32] = '{
			32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
			32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
			32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
			32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
			32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
			32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
			32'h00000001, 32'h00000000};

		function new();
			pitch = 1310720; turn = 5898240; zoom = 655360;
			rfloor = 65536; rceil = 6553600; enable = 1;
			yaw = 0; rad = 655360; count = 0; errors = 0;
		endfunction

		function longint rnd_shift(longint v, int s);
			return (v + (64'sd1 <<< (s - 1))) >>> s;
		endfunction

		function longint wrap(longint v);
			longint r;
			r = (v + Q_DEG180) % Q_DEG360;
			if (r < 0)
				r += Q_DEG360;
			return r - Q_DEG180;
		endfunction

		function bit [31:0] clip32(longint v);
			if (v > 64'sd2147483647)
				return 32'h7FFFFFFF;
			if (v < -64'sd2147483648)
				return 32'h80000000;
			return v[31:0];
		endfunction

		function void sincos(longint deg, output longint c, output longint s);
			longint z, x, y, dx, dy;
			z = rnd_shift(deg * RAD_PER_DEG, 18);
			x = GAIN_Q30;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_q30[i];
				end else begin
					x += dx; y -= dy; z += atan_q30[i];
				end
			end
			c = x;
			s = y;
		endfunction

		function void write_reg(reg_idx_t idx, bit [31:0] v);
			case (idx)
				REG_PITCH_ANGLE:    pitch = longint'($signed(v[23:0]));
				REG_TURN_RATE:      turn = longint'($signed(v));
				REG_ZOOM_RATE:      zoom = longint'($signed(v));
				REG_RADIUS_FLOOR:   rfloor = longint'({33'd0, v[30:0]});
				REG_RADIUS_CEILING: rceil = longint'({33'd0, v[30:0]});
				REG_INPUT_ENABLE:   enable = v[0];
				REG_START_YAW:      yaw = wrap(longint'($signed(v[24:0])));
				REG_START_RADIUS:   rad = longint'({33'd0, v[30:0]});
				default: ;
			endcase
		endfunction

		// Note an accepted frame; queue the placement it yields, if any.
		function void note_frame(frame_t f);
			longint look, zm, dt, cp, sp, cy, sy, rc;
			placement_t p;
			if (!f.playing || !f.cam)
				return;
			look = longint'($signed(f.look));
			zm = longint'($signed(f.zoom));
			dt = longint'({48'd0, f.dt});
			if (enable && f.present && dt > 0) begin
				yaw = wrap(yaw + rnd_shift(look * turn * dt, 30));
				rad -= rnd_shift(zm * zoom * dt, 30);
			end
			if (pitch > LIM_PITCH) pitch = LIM_PITCH;
			if (pitch < -LIM_PITCH) pitch = -LIM_PITCH;
			if (rad > rceil) rad = rceil;
			if (rad < rfloor) rad = rfloor;
			sincos(pitch, cp, sp);
			if (yaw > Q_DEG90) begin
				sincos(yaw - Q_DEG180, cy, sy);
				cy = -cy; sy = -sy;
			end else if (yaw < -Q_DEG90) begin
				sincos(yaw + Q_DEG180, cy, sy);
				cy = -cy; sy = -sy;
			end else begin
				sincos(yaw, cy, sy);
			end
			rc = rnd_shift(rad * cp, 30);
			count++;
			p.x = clip32(longint'($signed(f.px)) + rnd_shift(rc * sy, 30));
			p.y = clip32(longint'($signed(f.py)) + rnd_shift(rad * sp, 30));
			p.z = clip32(longint'($signed(f.pz)) + rnd_shift(rc * cy, 30));
			p.pitch = pitch[23:0];
			p.yaw = 25'(yaw + Q_DEG180);
			p.total = count;
			p.target = f.target;
			due.push_back(p);
		endfunction

		function void check(placement_t got);
			placement_t e;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected placement, total=%0d", got.total);
				return;
			end
			e = due.pop_front();
			if (got != e) begin
				errors++;
				if (errors <= 10) begin
					$display("placement diff exp x=%h y=%h z=%h p=%h yaw=%h n=%0d t=%h",
						e.x, e.y, e.z, e.pitch, e.yaw, e.total, e.target);
					$display("               got x=%h y=%h z=%h p=%h yaw=%h n=%0d t=%h",
						got.x, got.y, got.z, got.pitch, got.yaw, got.total, got.target);
				end
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ocp_frame_if frm_ch ();
	ocp_place_if plc_ch ();

	placement_board board;
	bit     quiet;          // when set, both sides run without idling
	int     placed_seen = 0;
	longint cycles = 0;

	orbit_camera_placement_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frm     (frm_ch.sink),
		.plc     (plc_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	// Bound the run; a hang ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("orbit_camera_placement_top: mismatch");
			$finish;
		end
	end

	// Pick an idle length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Write one register through an APB setup and access transaction.
	task automatic reg_write(reg_idx_t idx, bit [31:0] v);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		board.write_reg(idx, v);
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	// Offer one frame and hold it until the block takes it.
	task automatic send_frame(frame_t f);
		int g;
		g = gap_len();
		if (g > 0) begin
			frm_ch.valid = 0;
			repeat (g) @(negedge clk);
		end
		frm_ch.is_playing = f.playing;
		frm_ch.camera_found = f.cam;
		frm_ch.target_id = f.target;
		frm_ch.pivot_x = f.px;
		frm_ch.pivot_y = f.py;
		frm_ch.pivot_z = f.pz;
		frm_ch.input_present = f.present;
		frm_ch.look_axis = f.look;
		frm_ch.zoom_axis = f.zoom;
		frm_ch.frame_time = f.dt;
		frm_ch.valid = 1;
		do @(posedge clk); while (!frm_ch.ready);
		board.note_frame(f);
		@(negedge clk);
	endtask

	function automatic bit [15:0] axis_val();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 16'sd16384;
		if (r == 1) return -16'sd16384;
		if (r == 2) return 16'd0;
		return 16'($urandom_range(32768) - 16384);
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int r;
		r = $urandom_range(99);
		f.playing = (r >= 6);
		f.cam = (r < 6 || r >= 12);
		f.target = ($urandom_range(15) == 0) ? 32'hFFFFFFFF : $urandom;
		// pivots: mostly near the origin so the offset shows, sometimes anywhere
		f.px = ($urandom_range(3) == 0) ? $urandom : 32'($signed(16'($urandom))) <<< 8;
		f.py = ($urandom_range(3) == 0) ? $urandom : 32'($signed(16'($urandom))) <<< 8;
		f.pz = ($urandom_range(3) == 0) ? $urandom : 32'($signed(16'($urandom))) <<< 8;
		f.present = ($urandom_range(7) != 0);
		f.look = axis_val();
		f.zoom = axis_val();
		r = $urandom_range(9);
		f.dt = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r < 5) ? 16'($urandom) :
			16'($urandom_range(2000));
		return f;
	endfunction

	// Let everything in flight drain, then the block's own latency.
	task automatic drain();
		frm_ch.valid = 0;
		while (board.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	// One register setting per phase; the extremes come in the early phases.
	task automatic set_phase(int ph);
		bit [31:0] v[8];
		v[0] = 32'($urandom_range(2 * 5832704) - 5832704);
		v[1] = 32'($signed(($urandom_range(720) - 360))) <<< 16;
		v[2] = 32'($signed(($urandom_range(200) - 100))) <<< 16;
		v[3] = $urandom_range(65536 * 5);
		v[4] = $urandom_range(65536 * 2000, 65536 * 6);
		v[5] = ($urandom_range(4) != 0);
		v[6] = 32'($urandom_range(2 * 11796480) - 11796480);
		v[7] = $urandom_range(65536 * 50);
		case (ph)
			0: begin
				// hold the rates and the pitch at their extremes
				v[0] = 32'(5832704); v[1] = 32'h7FFFFFFF; v[2] = 32'h80000000;
				v[6] = 32'(11796480); v[7] = 32'h7FFFFFFF; v[4] = 32'h7FFFFFFF;
			end
			1: begin
				v[0] = 32'(-5832704); v[1] = 32'h80000000; v[2] = 32'h7FFFFFFF;
				v[6] = 32'(-11796480); v[7] = 0; v[3] = 0; v[4] = 0;
			end
			2: begin
				// floor above the ceiling: the floor wins
				v[3] = 32'(65536 * 30); v[4] = 32'(65536 * 5); v[5] = 0;
				v[0] = 32'h00FFFFFF;
			end
			3: begin
				v[0] = 32'h007FFFFF; v[5] = 1; v[3] = 32'h7FFFFFFF; v[4] = 32'h7FFFFFFF;
			end
			default: ;
		endcase
		for (int i = 0; i < 8; i++)
			reg_write(reg_idx_t'(i), v[i]);
	endtask

	// Placement receiver: random stalls, one long hold-off to back up the block.
	initial begin
		int stall_left;
		bit held;
		placement_t got;
		stall_left = 0;
		held = 0;
		plc_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (plc_ch.valid && plc_ch.ready) begin
				got.x = plc_ch.cam_x;
				got.y = plc_ch.cam_y;
				got.z = plc_ch.cam_z;
				got.pitch = plc_ch.aim_pitch;
				got.yaw = plc_ch.aim_yaw;
				got.total = plc_ch.placed_total;
				got.target = plc_ch.last_target;
				board.check(got);
				placed_seen++;
			end
			@(negedge clk);
			if (!held && placed_seen >= 300) begin
				held = 1;
				stall_left = HOLD_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				plc_ch.ready = 0;
			end else if (quiet || $urandom_range(99) < 65) begin
				plc_ch.ready = 1;
			end else begin
				stall_left = gap_len();
				plc_ch.ready = 0;
			end
		end
	end

	initial begin
		frame_t f;
		board = new();
		quiet = 0;
		frm_ch.valid = 0;
		frm_ch.is_playing = 0;
		frm_ch.camera_found = 0;
		frm_ch.target_id = 0;
		frm_ch.pivot_x = 0;
		frm_ch.pivot_y = 0;
		frm_ch.pivot_z = 0;
		frm_ch.input_present = 0;
		frm_ch.look_axis = 0;
		frm_ch.zoom_axis = 0;
		frm_ch.frame_time = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);

		// Directed frames at reset settings.
		f = random_frame();
		f.playing = 1; f.cam = 1; f.present = 1;
		f.px = 0; f.py = 0; f.pz = 0;
		f.look = 16'sd16384; f.zoom = 16'sd16384; f.dt = 16'hFFFF; f.target = 32'hFFFFFFFF;
		send_frame(f);
		f.look = -16'sd16384; f.zoom = -16'sd16384; f.target = 0;
		send_frame(f);
		f.playing = 0;                          // not playing: dropped
		send_frame(f);
		f.playing = 1; f.cam = 0;               // no camera: dropped
		send_frame(f);
		f.cam = 1; f.dt = 0;                    // no integration from zero time
		send_frame(f);
		f.dt = 16'd1000; f.present = 0;         // no input source
		send_frame(f);
		f.present = 1;
		f.px = 32'h7FFFFFFF; f.py = 32'h7FFFFFFF; f.pz = 32'h7FFFFFFF;
		send_frame(f);                          // position saturates high
		f.px = 32'h80000000; f.py = 32'h80000000; f.pz = 32'h80000000;
		f.look = 16'sd8192;
		send_frame(f);                          // and low
		f.px = 32'h12345678; f.py = 32'hEDCBA987; f.pz = 32'h00010000;
		f.zoom = 16'sd16384; f.dt = 16'hFFFF;   // drive the radius into the floor
		repeat (3) send_frame(f);
		f.zoom = -16'sd16384;                   // and out to the ceiling
		repeat (12) send_frame(f);
		drain();
		reg_write(REG_INPUT_ENABLE, 0);         // axes locked out
		send_frame(f);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			set_phase(ph);
			quiet = (ph == 5);
			for (int k = 0; k < PHASE_LEN; k++)
				send_frame(random_frame());
			drain();
		end

		if (board.errors == 0 && board.due.size() == 0)
			$display("orbit_camera_placement_top: match");
		else
			$display("orbit_camera_placement_top: mismatch");
		$finish;
	end

endmodule
